// ===== hw/rtl/bpd_pkg.sv =====
`default_nettype none
package bpd_pkg;

  localparam int PACKET_BYTES = 33;
  localparam int MAX_CHANNELS = 8;

  localparam int POS_W    = $clog2(PACKET_BYTES);
  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WC_W     = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W    = 4;
  localparam int SCALE_W  = 24;
  localparam int RAW_W    = 24;
  localparam int SCALED_W = 48;
  localparam int IDX_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_SCALE_FACTOR  = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTE   = 2'd2;
  localparam logic [1:0] REG_FOOTER_BYTE   = 2'd3;

  localparam logic [CNT_W-1:0]   RST_CHANNEL_COUNT = 4'd8;
  localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR  = 24'd1465;
  localparam logic [BYTE_W-1:0]  RST_HEADER_BYTE   = 8'hA0;
  localparam logic [BYTE_W-1:0]  RST_FOOTER_BYTE   = 8'hC0;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bpd_byte_if.sv =====
`default_nettype none
interface bpd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [bpd_pkg::BYTE_W-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bpd_result_if.sv =====
`default_nettype none
interface bpd_result_if;
  logic                               valid;
  logic                               ready;
  logic [bpd_pkg::BYTE_W-1:0]         sample_number;
  logic [bpd_pkg::IDX_W-1:0]          channel_index;
  logic signed [bpd_pkg::RAW_W-1:0]   raw_value;
  logic signed [bpd_pkg::SCALED_W-1:0] scaled_value;
  logic                               last_channel;

  modport source(output valid, output sample_number, output channel_index,
                 output raw_value, output scaled_value, output last_channel,
                 input ready);
  modport sink(input valid, input sample_number, input channel_index,
               input raw_value, input scaled_value, input last_channel,
               output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/biosignal_packet_deframer_top.sv =====
`default_nettype none
// Bytes are taken while no readout runs. A good footer byte starts a
// readout of n channels in three steps each (memory read, multiply, output
// register, held until taken); the first result follows the read and
// multiply steps, and no byte is taken until the last one leaves.
// Synchronous reset restores the register defaults and clears the framer;
// the channel memory is not cleared, as every channel is written before use.
module biosignal_packet_deframer_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bpd_byte_if.sink                          rx,
  bpd_result_if.source                      res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bpd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bpd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bpd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  logic [bpd_pkg::CNT_W-1:0]   channel_count;
  logic [bpd_pkg::SCALE_W-1:0] scale_factor;
  logic [bpd_pkg::BYTE_W-1:0]  header_byte;
  logic [bpd_pkg::BYTE_W-1:0]  footer_byte;

  bpd_pkg::state_t state, state_next;

  logic [bpd_pkg::POS_W-1:0]  byte_position;
  logic                       hunting;
  logic                       header_ok;
  logic [bpd_pkg::BYTE_W-1:0] sample_number;
  logic [bpd_pkg::WC_W-1:0]   wr_chan;
  logic [1:0]                 byte_sel;
  logic [15:0]                partial;
  logic [bpd_pkg::CH_W-1:0]   rd_chan;

  logic                                 ram_wr_en;
  logic                                 ram_rd_en;
  logic [bpd_pkg::RAW_W-1:0]            ram_rd_data;
  logic                                 rx_fire;
  logic                                 tx_fire;
  logic                                 at_footer;
  logic                                 frame_good;
  logic                                 last_read;
  logic [bpd_pkg::CNT_W-1:0]            n_eff;
  logic signed [bpd_pkg::RAW_W-1:0]     raw_s;
  logic signed [bpd_pkg::SCALE_W:0]     scale_s;
  logic signed [bpd_pkg::RAW_W+bpd_pkg::SCALE_W:0] product;
  logic                                 cfg_wr;

  logic [bpd_pkg::IDX_W-1:0]            out_index;
  logic signed [bpd_pkg::RAW_W-1:0]     out_raw;
  logic signed [bpd_pkg::SCALED_W-1:0]  out_scaled;
  logic                                 out_last;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= bpd_pkg::RST_CHANNEL_COUNT;
      scale_factor  <= bpd_pkg::RST_SCALE_FACTOR;
      header_byte   <= bpd_pkg::RST_HEADER_BYTE;
      footer_byte   <= bpd_pkg::RST_FOOTER_BYTE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bpd_pkg::REG_CHANNEL_COUNT: channel_count <= pwdata[bpd_pkg::CNT_W-1:0];
        bpd_pkg::REG_SCALE_FACTOR:  scale_factor  <= pwdata[bpd_pkg::SCALE_W-1:0];
        bpd_pkg::REG_HEADER_BYTE:   header_byte   <= pwdata[bpd_pkg::BYTE_W-1:0];
        bpd_pkg::REG_FOOTER_BYTE:   footer_byte   <= pwdata[bpd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bpd_pkg::REG_CHANNEL_COUNT: prdata = bpd_pkg::PDATA_W'(channel_count);
      bpd_pkg::REG_SCALE_FACTOR:  prdata = bpd_pkg::PDATA_W'(scale_factor);
      bpd_pkg::REG_HEADER_BYTE:   prdata = bpd_pkg::PDATA_W'(header_byte);
      bpd_pkg::REG_FOOTER_BYTE:   prdata = bpd_pkg::PDATA_W'(footer_byte);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    if (channel_count == '0) begin
      n_eff = bpd_pkg::CNT_W'(1);
    end else if (channel_count > bpd_pkg::CNT_W'(bpd_pkg::MAX_CHANNELS)) begin
      n_eff = bpd_pkg::CNT_W'(bpd_pkg::MAX_CHANNELS);
    end else begin
      n_eff = channel_count;
    end
  end

  assign rx_fire    = rx.valid && rx.ready;
  assign tx_fire    = res.valid && res.ready;
  assign at_footer  = !hunting && (byte_position == bpd_pkg::POS_W'(bpd_pkg::PACKET_BYTES - 1));
  assign frame_good = at_footer && header_ok && (rx.rx_byte == footer_byte);
  assign last_read  = (bpd_pkg::CNT_W'(rd_chan) + bpd_pkg::CNT_W'(1)) == n_eff;

  assign ram_wr_en = rx_fire && !hunting && (byte_position > bpd_pkg::POS_W'(1)) &&
                     !at_footer && (wr_chan < bpd_pkg::WC_W'(bpd_pkg::MAX_CHANNELS)) &&
                     (byte_sel == 2'd2);

  always_comb begin
    state_next = state;
    case (state)
      bpd_pkg::ST_RECV: begin
        if (rx_fire && frame_good) begin
          state_next = bpd_pkg::ST_READ;
        end
      end
      bpd_pkg::ST_READ: state_next = bpd_pkg::ST_MUL;
      bpd_pkg::ST_MUL:  state_next = bpd_pkg::ST_OUT;
      bpd_pkg::ST_OUT: begin
        if (res.ready) begin
          state_next = out_last ? bpd_pkg::ST_RECV : bpd_pkg::ST_READ;
        end
      end
      default: state_next = bpd_pkg::ST_RECV;
    endcase
  end

  always_comb begin
    rx.ready  = 1'b0;
    res.valid = 1'b0;
    ram_rd_en = 1'b0;
    case (state)
      bpd_pkg::ST_RECV: rx.ready  = 1'b1;
      bpd_pkg::ST_READ: ram_rd_en = 1'b1;
      bpd_pkg::ST_MUL:  ;
      bpd_pkg::ST_OUT:  res.valid = 1'b1;
      default: ;
    endcase
  end

  bpd_ram #(
    .WIDTH(bpd_pkg::RAW_W),
    .DEPTH(bpd_pkg::MAX_CHANNELS)
  ) u_chan_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(wr_chan[bpd_pkg::CH_W-1:0]),
    .wr_data({partial, rx.rx_byte}),
    .rd_en  (ram_rd_en),
    .rd_addr(rd_chan),
    .rd_data(ram_rd_data)
  );

  assign raw_s   = $signed(ram_rd_data);
  assign scale_s = $signed({1'b0, scale_factor});
  assign product = raw_s * scale_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bpd_pkg::ST_RECV;
      byte_position <= '0;
      hunting       <= 1'b0;
      header_ok     <= 1'b0;
      sample_number <= '0;
      wr_chan       <= '0;
      byte_sel      <= '0;
      rd_chan       <= '0;
    end else begin
      state <= state_next;
      if (rx_fire) begin
        if (hunting) begin
          if (rx.rx_byte == header_byte) begin
            hunting       <= 1'b0;
            header_ok     <= 1'b1;
            byte_position <= bpd_pkg::POS_W'(1);
          end
        end else if (byte_position == '0) begin
          header_ok     <= (rx.rx_byte == header_byte);
          byte_position <= bpd_pkg::POS_W'(1);
        end else if (!at_footer) begin
          if (byte_position == bpd_pkg::POS_W'(1)) begin
            sample_number <= rx.rx_byte;
            wr_chan       <= '0;
            byte_sel      <= '0;
          end else if (wr_chan < bpd_pkg::WC_W'(bpd_pkg::MAX_CHANNELS)) begin
            if (byte_sel == 2'd2) begin
              byte_sel <= '0;
              wr_chan  <= wr_chan + bpd_pkg::WC_W'(1);
            end else begin
              byte_sel <= byte_sel + 2'd1;
            end
          end
          byte_position <= byte_position + bpd_pkg::POS_W'(1);
        end else begin
          byte_position <= '0;
          header_ok     <= 1'b0;
          hunting       <= !frame_good;
        end
      end
      if (rx_fire && frame_good) begin
        rd_chan <= '0;
      end else if (state == bpd_pkg::ST_OUT && tx_fire && !out_last) begin
        rd_chan <= rd_chan + bpd_pkg::CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire) begin
      partial <= {partial[7:0], rx.rx_byte};
    end
    if (state == bpd_pkg::ST_MUL) begin
      out_index  <= bpd_pkg::IDX_W'(rd_chan);
      out_raw    <= raw_s;
      out_scaled <= product[bpd_pkg::SCALED_W-1:0];
      out_last   <= last_read;
    end
  end

  assign res.sample_number = sample_number;
  assign res.channel_index = out_index;
  assign res.raw_value     = out_raw;
  assign res.scaled_value  = out_scaled;
  assign res.last_channel  = out_last;

endmodule
`default_nettype wire

// ===== hw/rtl/bpd_ram.sv =====
`default_nettype none
module bpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic                                        rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== test/bpd_result_checker.sv =====
module bpd_result_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bpd_byte_if                               rx,
  bpd_result_if                             res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic                         pready,
  input  wire logic [bpd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bpd_pkg::PDATA_W-1:0]  pwdata,
  output int                                errors,
  output int                                pending
);
  import bpd_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0]          sample_number;
    logic [IDX_W-1:0]           channel_index;
    logic signed [RAW_W-1:0]    raw_value;
    logic signed [SCALED_W-1:0] scaled_value;
    logic                       last_channel;
  } channel_result_t;

  channel_result_t expected_results[$];

  logic [CNT_W-1:0]   cfg_channels;
  logic [SCALE_W-1:0] cfg_scale;
  logic [BYTE_W-1:0]  cfg_header;
  logic [BYTE_W-1:0]  cfg_footer;

  int unsigned        frame_pos;
  logic               hunting;
  logic               header_seen;
  logic [BYTE_W-1:0]  frame_sample;
  logic [RAW_W-1:0]   channel_words [MAX_CHANNELS];

  task automatic frame_byte(input logic [BYTE_W-1:0] b);
    int unsigned offset;
    int unsigned active;
    int c;
    channel_result_t r;
    logic signed [SCALED_W-1:0] wide_raw;
    if (hunting) begin
      if (b == cfg_header) begin
        hunting = 1'b0;
        header_seen = 1'b1;
        frame_pos = 1;
      end
    end else if (frame_pos == 0) begin
      header_seen = (b == cfg_header);
      frame_pos = 1;
    end else if (frame_pos < PACKET_BYTES - 1) begin
      if (frame_pos == 1) begin
        frame_sample = b;
      end else begin
        offset = frame_pos - 2;
        if (offset / 3 < MAX_CHANNELS) begin
          channel_words[CH_W'(offset / 3)][(2 - offset % 3) * 8 +: 8] = b;
        end
      end
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (!header_seen || b != cfg_footer) begin
        hunting = 1'b1;
        header_seen = 1'b0;
      end else begin
        header_seen = 1'b0;
        if (cfg_channels == 0) begin
          active = 1;
        end else if (cfg_channels > MAX_CHANNELS) begin
          active = MAX_CHANNELS;
        end else begin
          active = {28'd0, cfg_channels};
        end
        for (c = 0; c < active; c++) begin
          r.sample_number = frame_sample;
          r.channel_index = IDX_W'(c);
          r.raw_value = channel_words[CH_W'(c)];
          wide_raw = SCALED_W'(r.raw_value);
          r.scaled_value = wide_raw * $signed({{(SCALED_W - SCALE_W){1'b0}}, cfg_scale});
          r.last_channel = (c + 1 == active);
          expected_results.push_back(r);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin
    channel_result_t want;
    if (rst) begin
      cfg_channels = RST_CHANNEL_COUNT;
      cfg_scale = RST_SCALE_FACTOR;
      cfg_header = RST_HEADER_BYTE;
      cfg_footer = RST_FOOTER_BYTE;
      frame_pos = 0;
      hunting = 1'b0;
      header_seen = 1'b0;
      frame_sample = '0;
      foreach (channel_words[i]) channel_words[i] = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, got channel %0d raw %0d", $time,
                   res.channel_index, res.raw_value);
        end else begin
          want = expected_results.pop_front();
          check_field("sample_number", 64'(want.sample_number), 64'(res.sample_number));
          check_field("channel_index", 64'(want.channel_index), 64'(res.channel_index));
          check_field("raw_value", 64'(want.raw_value), 64'(res.raw_value));
          check_field("scaled_value", 64'(want.scaled_value), 64'(res.scaled_value));
          check_field("last_channel", 64'(want.last_channel), 64'(res.last_channel));
        end
      end
      if (rx.valid && rx.ready) begin
        frame_byte(rx.rx_byte);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_CHANNEL_COUNT: cfg_channels = pwdata[CNT_W-1:0];
          REG_SCALE_FACTOR:  cfg_scale = pwdata[SCALE_W-1:0];
          REG_HEADER_BYTE:   cfg_header = pwdata[BYTE_W-1:0];
          REG_FOOTER_BYTE:   cfg_footer = pwdata[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import bpd_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int TARGET_BYTES    = 360;
  localparam int MIN_PHASES      = 6;
  localparam int PACKETS_PER_PHASE = 2;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  bpd_byte_if   rx();
  bpd_result_if res();

  bit               hold_requested = 1'b0;
  bit               send_burst = 1'b0;
  bit               take_burst = 1'b0;
  int               counted_bytes = 0;
  int               idle_cycles = 0;
  logic [BYTE_W-1:0] cur_header;
  logic [BYTE_W-1:0] cur_footer;
  logic [RAW_W-1:0]  packet_words [MAX_CHANNELS];

  always #10 clk = ~clk;

  biosignal_packet_deframer_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bpd_result_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always @(posedge clk) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    res.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
        gap = take_burst ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && res.ready));
    end
  end

  function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] v);
    return v ^ BYTE_W'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!(rx.valid && rx.ready));
  endtask

  task automatic send_packet(input bit bad_header, input bit bad_footer);
    logic [BYTE_W-1:0] frame [PACKET_BYTES];
    int ch;
    frame[0] = bad_header ? other_than(cur_header) : cur_header;
    frame[1] = BYTE_W'($urandom);
    for (int i = 2; i < PACKET_BYTES - 1; i++) frame[i] = BYTE_W'($urandom);
    for (ch = 0; ch < MAX_CHANNELS; ch++) begin
      frame[2 + 3 * ch] = packet_words[ch][23:16];
      frame[3 + 3 * ch] = packet_words[ch][15:8];
      frame[4 + 3 * ch] = packet_words[ch][7:0];
    end
    frame[PACKET_BYTES - 1] = bad_footer ? other_than(cur_footer) : cur_footer;
    foreach (frame[i]) send_byte(frame[i]);
    counted_bytes += PACKET_BYTES;
  endtask

  task automatic randomize_words();
    foreach (packet_words[i]) begin
      case ($urandom_range(0, 5))
        0: packet_words[i] = 24'h800000;
        1: packet_words[i] = 24'h7FFFFF;
        2: packet_words[i] = 24'h000000;
        3: packet_words[i] = 24'hFFFFFF;
        default: packet_words[i] = RAW_W'($urandom);
      endcase
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] count, input logic [SCALE_W-1:0] scale,
                           input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] ftr);
    write_reg(REG_CHANNEL_COUNT, {28'($urandom), count});
    write_reg(REG_SCALE_FACTOR, {8'($urandom), scale});
    write_reg(REG_HEADER_BYTE, {24'($urandom), hdr});
    write_reg(REG_FOOTER_BYTE, {24'($urandom), ftr});
    cur_header = hdr;
    cur_footer = ftr;
  endtask

  task automatic settle();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int k;
    int pick;
    int noise_len;
    logic [BYTE_W-1:0] filler;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rx.valid <= 1'b0;
    rx.rx_byte <= '0;
    cur_header = RST_HEADER_BYTE;
    cur_footer = RST_FOOTER_BYTE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    packet_words = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF,
                     24'h000001, 24'h800001, 24'h555555, 24'hAAAAAA};
    send_packet(1'b0, 1'b0);
    settle();

    phase = 0;
    while (phase < MIN_PHASES || counted_bytes < TARGET_BYTES) begin
      case (phase)
        0: configure(4'd1, 24'hFFFFFF, 8'h00, 8'hFF);
        1: configure(4'd0, 24'd0, 8'hFF, 8'h00);
        2: configure(4'd15, 24'd1, 8'h5A, 8'h5A);
        3: configure(4'd8, 24'hFFFFFF, RST_HEADER_BYTE, RST_FOOTER_BYTE);
        default: configure(CNT_W'($urandom), SCALE_W'($urandom), BYTE_W'($urandom),
                           BYTE_W'($urandom));
      endcase
      // The receiver stalls after the first word of this phase, holding back the packet bytes that follow.
      if (phase == 3) hold_requested = 1'b1;
      for (k = 0; k < PACKETS_PER_PHASE; k++) begin
        pick = (phase == 3) ? 0 : $urandom_range(0, 9);
        randomize_words();
        if (pick < 7) begin
          send_packet(1'b0, 1'b0);
        end else if (pick == 7) begin
          send_packet(1'b1, 1'b0);
        end else if (pick == 8) begin
          send_packet(1'b0, 1'b1);
        end else begin
          noise_len = $urandom_range(1, 40);
          for (int i = 0; i < noise_len; i++) begin
            send_byte((i == 0 && $urandom_range(0, 1) == 1) ? cur_header : 8'($urandom));
          end
          counted_bytes += noise_len;
          // A full packet length of bytes that match neither marker leaves the framer hunting.
          do filler = BYTE_W'($urandom); while (filler == cur_header || filler == cur_footer);
          repeat (PACKET_BYTES) send_byte(filler);
          counted_bytes += PACKET_BYTES;
        end
      end
      settle();
      phase++;
    end

    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
